>>> hdl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the bitmap block allocator: beat layouts,
// operation and status codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int UNIT_BYTES_DEF = 128;
  localparam int MAP_WORDS_DEF  = 32;

  localparam int SIZE_W   = 18;
  localparam int OFFS_W   = 17;
  localparam int COUNT_W  = 11;
  localparam int WORD_W   = 32;
  localparam int BIT_W    = 5;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } bba_kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_RUN      = 3'd1,
    ST_BAD_SIZE    = 3'd2,
    ST_DOUBLE_FREE = 3'd3,
    ST_OUTSIDE     = 3'd4
  } bba_status_t;

  typedef struct packed {
    bba_kind_t           kind;
    logic [SIZE_W-1:0]   size_bytes;
    logic [OFFS_W-1:0]   block_offset;
  } bba_in_t;

  typedef struct packed {
    bba_status_t         status;
    logic [OFFS_W-1:0]   granted_offset;
    logic [COUNT_W-1:0]  units_in_use;
  } bba_out_t;

endpackage

`default_nettype wire

>>> hdl/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// Allocates and frees blocks of fixed-size units from one store, tracking a
// used bit per unit in a RAM of 32-bit map words.
//
// A command beat is taken on a rising edge with start high and busy low.
// in_data.kind selects allocate or free; the size is rounded up to units.
// Exactly one result beat follows, shown for one cycle with out_valid high;
// the receiver cannot stall it, and busy has dropped in that same cycle so
// the next command may be taken there.
// A rejected size or range reads no map word. A small allocate reads map
// words upward until a gap is found; a large allocate reads words downward,
// then marks the run it found. A free checks each map word the block spans,
// stopping at a double free, and then reads and clears those words again.
// The operands are registered first, then the unit quotients; map words are
// read one per cycle through the RAM's single read port.
// After reset a clearing pass writes zero to each map word, with busy high.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator #(
  parameter int UNIT_BYTES = bba_pkg::UNIT_BYTES_DEF,
  parameter int MAP_WORDS  = bba_pkg::MAP_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  bba_pkg::bba_in_t  in_data,
  output logic              busy,
  output logic              out_valid,
  output bba_pkg::bba_out_t out_data
);

  import bba_pkg::*;

  localparam int AW          = $clog2(MAP_WORDS);
  localparam int AC_W        = $clog2(MAP_WORDS + 1);
  localparam int UIW         = AW + BIT_W;
  localparam int TOTAL_UNITS = MAP_WORDS * WORD_W;
  localparam int STORE_BYTES = TOTAL_UNITS * UNIT_BYTES;
  localparam int NEED_W      = SIZE_W + 1;
  localparam int CNT_W       = ($clog2(TOTAL_UNITS + 1) > COUNT_W) ?
                               $clog2(TOTAL_UNITS + 1) : COUNT_W;

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b00_0000_0001,
    S_IDLE    = 10'b00_0000_0010,
    S_DIV     = 10'b00_0000_0100,
    S_DECIDE  = 10'b00_0000_1000,
    S_SCAN_S  = 10'b00_0001_0000,
    S_SCAN_L  = 10'b00_0010_0000,
    S_MARK_L  = 10'b00_0100_0000,
    S_CHECK_F = 10'b00_1000_0000,
    S_CLEAR_F = 10'b01_0000_0000,
    S_FIN     = 10'b10_0000_0000
  } state_t;

  state_t              state_r, state_nxt;
  bba_kind_t           kind_r, kind_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [OFFS_W-1:0]   offs_r, offs_nxt;
  logic [NEED_W-1:0]   need_r, need_nxt;
  bba_status_t         status_r, status_nxt;
  logic [UIW-1:0]      start_r, start_nxt;
  logic [AW-1:0]       rd_addr_r, rd_addr_nxt;
  logic                rd_on_r, rd_on_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]       ev_addr_r, ev_addr_nxt;
  logic [AW-1:0]       end_addr_r, end_addr_nxt;
  logic [AW-1:0]       fw_r, fw_nxt;
  logic [BIT_W-1:0]    s_lo_r, s_lo_nxt;
  logic [BIT_W-1:0]    e_hi_r, e_hi_nxt;
  logic [AC_W-1:0]     words_r, words_nxt;
  logic [AC_W-1:0]     run_r, run_nxt;
  logic [AC_W-1:0]     mark_left_r, mark_left_nxt;
  logic [AW-1:0]       wr_addr_r, wr_addr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  bba_out_t            out_r, out_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [WORD_W-1:0]   ram_rdata;

  logic                accept;
  logic [NEED_W-1:0]   need_q;
  logic [OFFS_W-1:0]   unit_q;

  logic [WORD_W-1:0]   sm_mask;
  logic [WORD_W-1:0]   last_mask;
  logic [WORD_W-1:0]   fr_mask;
  logic [BIT_W-1:0]    m_lo, m_hi;
  logic                hit;
  logic [BIT_W-1:0]    pos;
  logic [UIW-1:0]      s_unit, e_unit;
  logic [31:0]         prod;

  assign accept = start && (state_r == S_IDLE);

  bba_div #(
    .NUM_W (NEED_W),
    .DEN   (UNIT_BYTES)
  ) u_div_need (
    .clk   (clk),
    .start (accept),
    .num   (NEED_W'(in_data.size_bytes) + NEED_W'(UNIT_BYTES - 1)),
    .quot  (need_q)
  );

  bba_div #(
    .NUM_W (OFFS_W),
    .DEN   (UNIT_BYTES)
  ) u_div_unit (
    .clk   (clk),
    .start (accept),
    .num   (in_data.block_offset),
    .quot  (unit_q)
  );

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  // gap search inside one map word, lowest position first
  always_comb begin
    sm_mask = (WORD_W'(1) << need_r[BIT_W-1:0]) - WORD_W'(1);
    hit     = 1'b0;
    pos     = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if ((b + int'(need_r[BIT_W-1:0]) <= WORD_W) &&
          ((ram_rdata & (sm_mask << b)) == '0)) begin
        hit = 1'b1;
        pos = BIT_W'(b);
      end
    end
  end

  always_comb begin
    last_mask = (need_r[BIT_W-1:0] == '0) ? '1 :
                (WORD_W'(1) << need_r[BIT_W-1:0]) - WORD_W'(1);
    m_lo      = (ev_addr_r == fw_r) ? s_lo_r : '0;
    m_hi      = (ev_addr_r == end_addr_r) ? e_hi_r : BIT_W'(WORD_W - 1);
    fr_mask   = ({WORD_W{1'b1}} << m_lo) &
                ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - m_hi));
    s_unit    = UIW'(unit_q);
    e_unit    = UIW'(32'(unit_q) + 32'(need_q) - 32'd1);
    prod      = 32'(start_r) * 32'(UNIT_BYTES);
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    size_nxt      = size_r;
    offs_nxt      = offs_r;
    need_nxt      = need_r;
    status_nxt    = status_r;
    start_nxt     = start_r;
    rd_addr_nxt   = rd_addr_r;
    rd_on_nxt     = rd_on_r;
    rd_vld_nxt    = 1'b0;
    ev_addr_nxt   = rd_addr_r;
    end_addr_nxt  = end_addr_r;
    fw_nxt        = fw_r;
    s_lo_nxt      = s_lo_r;
    e_hi_nxt      = e_hi_r;
    words_nxt     = words_r;
    run_nxt       = run_r;
    mark_left_nxt = mark_left_r;
    wr_addr_nxt   = wr_addr_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = ev_addr_r;
    ram_wdata     = '0;

    // read issue, upward for the small search and free passes, downward for
    // the large search
    if (state_r == S_SCAN_S || state_r == S_CHECK_F || state_r == S_CLEAR_F) begin
      rd_vld_nxt = rd_on_r;
      if (rd_on_r) begin
        if (rd_addr_r == end_addr_r) begin
          rd_on_nxt = 1'b0;
        end else begin
          rd_addr_nxt = rd_addr_r + AW'(1);
        end
      end
    end else if (state_r == S_SCAN_L) begin
      rd_vld_nxt = rd_on_r;
      if (rd_on_r) begin
        if (rd_addr_r == '0) begin
          rd_on_nxt = 1'b0;
        end else begin
          rd_addr_nxt = rd_addr_r - AW'(1);
        end
      end
    end

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = wr_addr_r;
        ram_wdata = '0;
        if (wr_addr_r == AW'(MAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          wr_addr_nxt = wr_addr_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          kind_nxt  = in_data.kind;
          size_nxt  = in_data.size_bytes;
          offs_nxt  = in_data.block_offset;
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        state_nxt = S_DECIDE;
      end

      S_DECIDE: begin
        need_nxt   = need_q;
        status_nxt = ST_OK;
        start_nxt  = '0;
        rd_vld_nxt = 1'b0;
        run_nxt    = '0;
        if (kind_r == KIND_ALLOC) begin
          if (size_r == '0 || 32'(need_q) > 32'(TOTAL_UNITS)) begin
            status_nxt = ST_BAD_SIZE;
            state_nxt  = S_FIN;
          end else if (32'(need_q) < 32'(WORD_W)) begin
            rd_addr_nxt  = '0;
            end_addr_nxt = AW'(MAP_WORDS - 1);
            rd_on_nxt    = 1'b1;
            state_nxt    = S_SCAN_S;
          end else begin
            words_nxt   = AC_W'((32'(need_q) + 32'(WORD_W - 1)) >> BIT_W);
            rd_addr_nxt = AW'(MAP_WORDS - 1);
            rd_on_nxt   = 1'b1;
            state_nxt   = S_SCAN_L;
          end
        end else begin
          if (size_r == '0) begin
            status_nxt = ST_BAD_SIZE;
            state_nxt  = S_FIN;
          end else if (32'(offs_r) >= 32'(STORE_BYTES) ||
                       32'(offs_r) + 32'(size_r) > 32'(STORE_BYTES)) begin
            status_nxt = ST_OUTSIDE;
            state_nxt  = S_FIN;
          end else begin
            fw_nxt       = s_unit[UIW-1:BIT_W];
            end_addr_nxt = e_unit[UIW-1:BIT_W];
            s_lo_nxt     = s_unit[BIT_W-1:0];
            e_hi_nxt     = e_unit[BIT_W-1:0];
            rd_addr_nxt  = s_unit[UIW-1:BIT_W];
            rd_on_nxt    = 1'b1;
            state_nxt    = S_CHECK_F;
          end
        end
      end

      S_SCAN_S: begin
        if (rd_vld_r) begin
          if (hit) begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | (sm_mask << pos);
            start_nxt = {ev_addr_r, pos};
            rd_on_nxt = 1'b0;
            state_nxt = S_FIN;
          end else if (ev_addr_r == end_addr_r) begin
            status_nxt = ST_NO_RUN;
            state_nxt  = S_FIN;
          end
        end
      end

      S_SCAN_L: begin
        if (rd_vld_r) begin
          if (ram_rdata == '0 && (run_r + AC_W'(1)) == words_r) begin
            start_nxt     = {ev_addr_r, BIT_W'(0)};
            wr_addr_nxt   = ev_addr_r;
            mark_left_nxt = words_r;
            rd_on_nxt     = 1'b0;
            state_nxt     = S_MARK_L;
          end else if (ev_addr_r == '0) begin
            status_nxt = ST_NO_RUN;
            state_nxt  = S_FIN;
          end else if (ram_rdata == '0) begin
            run_nxt = run_r + AC_W'(1);
          end else begin
            run_nxt = '0;
          end
        end
      end

      S_MARK_L: begin
        ram_we        = 1'b1;
        ram_waddr     = wr_addr_r;
        ram_wdata     = (mark_left_r == AC_W'(1)) ? last_mask : '1;
        wr_addr_nxt   = wr_addr_r + AW'(1);
        mark_left_nxt = mark_left_r - AC_W'(1);
        if (mark_left_r == AC_W'(1)) begin
          state_nxt = S_FIN;
        end
      end

      S_CHECK_F: begin
        if (rd_vld_r) begin
          if ((ram_rdata & fr_mask) != fr_mask) begin
            status_nxt = ST_DOUBLE_FREE;
            rd_on_nxt  = 1'b0;
            state_nxt  = S_FIN;
          end else if (ev_addr_r == end_addr_r) begin
            rd_addr_nxt = fw_r;
            rd_on_nxt   = 1'b1;
            rd_vld_nxt  = 1'b0;
            state_nxt   = S_CLEAR_F;
          end
        end
      end

      S_CLEAR_F: begin
        if (rd_vld_r) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~fr_mask;
          if (ev_addr_r == end_addr_r) begin
            state_nxt = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (status_r == ST_OK) begin
          if (kind_r == KIND_ALLOC) begin
            cnt_nxt = cnt_r + CNT_W'(need_r);
          end else begin
            cnt_nxt = cnt_r - CNT_W'(need_r);
          end
        end
        out_nxt.status         = status_r;
        out_nxt.granted_offset = (status_r == ST_OK && kind_r == KIND_ALLOC) ?
                                 OFFS_W'(prod) : '0;
        out_nxt.units_in_use   = cnt_nxt[COUNT_W-1:0];
        out_valid_nxt          = 1'b1;
        state_nxt              = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      wr_addr_r   <= '0;
      rd_on_r     <= 1'b0;
      rd_vld_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      status_r    <= ST_OK;
      kind_r      <= KIND_ALLOC;
      run_r       <= '0;
      mark_left_r <= '0;
    end else begin
      state_r     <= state_nxt;
      wr_addr_r   <= wr_addr_nxt;
      rd_on_r     <= rd_on_nxt;
      rd_vld_r    <= rd_vld_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      kind_r      <= kind_nxt;
      run_r       <= run_nxt;
      mark_left_r <= mark_left_nxt;
    end
    size_r     <= size_nxt;
    offs_r     <= offs_nxt;
    need_r     <= need_nxt;
    start_r    <= start_nxt;
    rd_addr_r  <= rd_addr_nxt;
    ev_addr_r  <= ev_addr_nxt;
    end_addr_r <= end_addr_nxt;
    fw_r       <= fw_nxt;
    s_lo_r     <= s_lo_nxt;
    e_hi_r     <= e_hi_nxt;
    words_r    <= words_nxt;
    out_r      <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

>>> hdl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hdl/bba_div.sv
// ----------------------------------------------------------------------------
// bba_div
// Divider by a fixed divisor through a reciprocal multiply: one register on
// the operand, one on the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_div #(
  parameter int NUM_W = 19,
  parameter int DEN   = 128
) (
  input  logic             clk,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  output logic [NUM_W-1:0] quot
);

  localparam int     SH    = NUM_W + $clog2(DEN);
  localparam longint RECIP = ((longint'(1) << SH) / longint'(DEN)) + longint'(1);
  localparam int     RCP_W = NUM_W + 1;
  localparam int     PRD_W = NUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP_V = RCP_W'(RECIP);

  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] quot_r;
  logic [PRD_W-1:0] prod;

  // exact for every operand below 2**NUM_W
  assign prod = PRD_W'(num_r) * PRD_W'(RECIP_V);

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
    end
    quot_r <= NUM_W'(prod >> SH);
  end

  assign quot = quot_r;

endmodule

`default_nettype wire

>>> hdl/bba_chk.sv
// ----------------------------------------------------------------------------
// bba_chk
// Port-level checks of the bitmap block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input bba_pkg::bba_out_t out_data
);

  import bba_pkg::*;

  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_single_strobe : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_ends_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $fell(busy))
    else $error("result beat without a finished command");

  a_grant_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> (out_data.granted_offset == '0))
    else $error("granted offset set on a failed command");

endmodule

bind bitmap_block_allocator bba_chk u_bba_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire

>>> tb/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Watches the command and result channels of the bitmap block allocator.
// Each accepted command is run through a behavioural copy of the used-unit
// map and use counter. The predicted result is queued and compared field by
// field with the next result beat. Mismatch and outstanding-beat counts go
// back to the testbench top.
// ----------------------------------------------------------------------------
module bba_checker #(
  parameter int UNIT_BYTES = bba_pkg::UNIT_BYTES_DEF,
  parameter int MAP_WORDS  = bba_pkg::MAP_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  bba_pkg::bba_in_t  in_data,
  input  logic              out_valid,
  input  bba_pkg::bba_out_t out_data,
  output int                mismatches,
  output int                awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int TOTAL_UNITS = MAP_WORDS * WORD_W;
  localparam int STORE_BYTES = TOTAL_UNITS * UNIT_BYTES;

  logic [WORD_W-1:0] used_words [MAP_WORDS];
  int unsigned       units_held;
  bba_out_t          expected_results [$];
  int                errors;

  function automatic void mark_units(int unsigned first, int unsigned count, logic on);
    int unsigned u;
    for (u = first; u < first + count; u++) begin
      used_words[(u >> BIT_W) % MAP_WORDS][u % WORD_W] = on;
    end
  endfunction

  function automatic bba_out_t resolve_request(bba_in_t c);
    bba_out_t          r;
    int unsigned       need;
    int unsigned       first;
    int unsigned       u;
    int                w;
    int                b;
    int                i;
    int                words;
    int                lo;
    logic              found;
    logic              all_held;
    logic [WORD_W-1:0] mask;
    r.status         = ST_OK;
    r.granted_offset = '0;
    need  = (c.size_bytes + UNIT_BYTES - 1) / UNIT_BYTES;
    found = 1'b0;
    first = 0;
    if (c.kind == KIND_ALLOC) begin
      if (c.size_bytes == 0 || need > TOTAL_UNITS) begin
        r.status = ST_BAD_SIZE;
      end else begin
        if (need < WORD_W) begin
          // lowest gap inside one word, may end at the top bit
          mask = (32'd1 << need) - 32'd1;
          for (w = 0; w < MAP_WORDS && !found; w++) begin
            for (b = 0; b + need <= WORD_W && !found; b++) begin
              if ((used_words[w] & (mask << b)) == '0) begin
                found = 1'b1;
                first = w * WORD_W + b;
              end
            end
          end
        end else begin
          // highest run of empty words, searched downward
          words = (need + WORD_W - 1) / WORD_W;
          lo    = MAP_WORDS - words;
          found = (lo >= 0);
          for (i = MAP_WORDS - 1; found && i >= lo; i--) begin
            if (used_words[i] != '0) begin
              lo = i - words;
              if (lo < 0) found = 1'b0;
            end
          end
          first = lo * WORD_W;
        end
        if (!found) begin
          r.status = ST_NO_RUN;
        end else begin
          mark_units(first, need, 1'b1);
          units_held       = units_held + need;
          r.granted_offset = OFFS_W'(first * UNIT_BYTES);
        end
      end
    end else begin
      if (c.size_bytes == 0) begin
        r.status = ST_BAD_SIZE;
      end else if (c.block_offset >= STORE_BYTES ||
                   c.block_offset + c.size_bytes > STORE_BYTES) begin
        r.status = ST_OUTSIDE;
      end else begin
        first    = c.block_offset / UNIT_BYTES;
        all_held = 1'b1;
        for (u = first; u < first + need; u++) begin
          if (!used_words[(u >> BIT_W) % MAP_WORDS][u % WORD_W]) all_held = 1'b0;
        end
        if (!all_held) begin
          r.status = ST_DOUBLE_FREE;
        end else begin
          mark_units(first, need, 1'b0);
          units_held = (units_held >= need) ? units_held - need : 0;
        end
      end
    end
    r.units_in_use = COUNT_W'(units_held);
    return r;
  endfunction

  initial errors = 0;

  always @(posedge clk) begin : watch
    bba_out_t want;
    if (!rst_n) begin
      for (int k = 0; k < MAP_WORDS; k++) used_words[k] = '0;
      units_held = 0;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing outstanding: status %0d offset %0d units %0d",
                 out_data.status, out_data.granted_offset, out_data.units_in_use);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            errors++;
          end
          if (out_data.granted_offset !== want.granted_offset) begin
            $error("granted_offset: expected %0d, got %0d",
                   want.granted_offset, out_data.granted_offset);
            errors++;
          end
          if (out_data.units_in_use !== want.units_in_use) begin
            $error("units_in_use: expected %0d, got %0d",
                   want.units_in_use, out_data.units_in_use);
            errors++;
          end
        end
      end
      if (start && !busy) expected_results.push_back(resolve_request(in_data));
    end
    mismatches <= errors;
    awaited    <= expected_results.size();
  end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the bitmap block allocator. A directed run covers
// size limits, gaps ending at the top bit of a word, the large-run search,
// a full store, misaligned, double and out-of-store frees. A random run then
// mixes allocations of many sizes with frees of live blocks and some noise,
// with random gaps on the command side. The checker does the comparing.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int UNIT_BYTES   = UNIT_BYTES_DEF;
  localparam int MAP_WORDS    = MAP_WORDS_DEF;
  localparam int TOTAL_UNITS  = MAP_WORDS * WORD_W;
  localparam int STORE_BYTES  = TOTAL_UNITS * UNIT_BYTES;
  localparam int RANDOM_BEATS = 900;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct {
    logic [OFFS_W-1:0] offset;
    logic [SIZE_W-1:0] size;
  } held_block_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  logic     out_valid;
  bba_in_t  in_data;
  bba_out_t out_data;
  int       mismatches;
  int       awaited;

  bba_in_t     inflight;
  logic        track_live;
  logic        gaps_on;
  held_block_t live_blocks [$];
  held_block_t freed_blocks [$];
  int          status_seen [8];
  int          peak_units;
  int          directed_beats;
  int          random_beats;
  int          cycles;

  bitmap_block_allocator #(
    .UNIT_BYTES(UNIT_BYTES),
    .MAP_WORDS (MAP_WORDS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  bba_checker #(
    .UNIT_BYTES(UNIT_BYTES),
    .MAP_WORDS (MAP_WORDS)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .mismatches(mismatches),
    .awaited   (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bba_in_t make_cmd(bba_kind_t k, int unsigned size, int unsigned offs);
    bba_in_t c;
    c.kind         = k;
    c.size_bytes   = SIZE_W'(size);
    c.block_offset = OFFS_W'(offs);
    return c;
  endfunction

  // one command beat, with an optional gap in front of it
  task automatic issue(bba_in_t c);
    if (gaps_on && $urandom_range(99) < 29) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
    end
    in_data <= c;
    start   <= 1'b1;
    do @(posedge clk); while (busy || !rst_n);
    inflight = c;
  endtask

  function automatic bba_in_t random_alloc();
    int unsigned p;
    int unsigned bytes;
    p = $urandom_range(99);
    if (p < 70)      bytes = $urandom_range(1, 31 * UNIT_BYTES);
    else if (p < 92) bytes = $urandom_range(31 * UNIT_BYTES + 1, 160 * UNIT_BYTES);
    else if (p < 97) bytes = $urandom_range(160 * UNIT_BYTES + 1, STORE_BYTES);
    else             bytes = $urandom_range(STORE_BYTES + 1, (1 << SIZE_W) - 1);
    return make_cmd(KIND_ALLOC, bytes, 0);
  endfunction

  function automatic bba_in_t random_cmd();
    int unsigned p;
    int unsigned idx;
    int unsigned offs;
    held_block_t blk;
    p = $urandom_range(99);
    if (p < 12) begin
      // noise
      return make_cmd(bba_kind_t'($urandom_range(1)),
                      $urandom_range(1) ? $urandom_range(0, (1 << SIZE_W) - 1)
                                        : $urandom_range(0, 4 * UNIT_BYTES),
                      $urandom_range(0, STORE_BYTES - 1));
    end
    if (p < 16 && freed_blocks.size() > 0) begin
      blk = freed_blocks[$urandom_range(freed_blocks.size() - 1)];
      return make_cmd(KIND_FREE, blk.size, blk.offset);
    end
    if (live_blocks.size() > 0 &&
        $urandom_range(99) < ((live_blocks.size() > 48) ? 70 : 35)) begin
      idx  = $urandom_range(live_blocks.size() - 1);
      blk  = live_blocks[idx];
      live_blocks.delete(idx);
      freed_blocks.push_back(blk);
      if (freed_blocks.size() > 16) void'(freed_blocks.pop_front());
      offs = blk.offset;
      // misaligned offset inside the first unit
      if ($urandom_range(3) == 0) offs = offs + $urandom_range(1, UNIT_BYTES - 1);
      return make_cmd(KIND_FREE, blk.size, offs);
    end
    return random_alloc();
  endfunction

  // result bookkeeping on the falling edge, clear of the driving edge
  always @(negedge clk) begin
    if (rst_n && out_valid) begin
      status_seen[int'(out_data.status)]++;
      if (int'(out_data.units_in_use) > peak_units) peak_units = out_data.units_in_use;
      if (track_live && inflight.kind == KIND_ALLOC && out_data.status == ST_OK) begin
        live_blocks.push_back('{out_data.granted_offset, inflight.size_bytes});
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d beats outstanding", cycles, awaited);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_data        <= '0;
    inflight        = '0;
    track_live      = 1'b0;
    gaps_on         = 1'b1;
    peak_units      = 0;
    directed_beats  = 0;
    random_beats    = 0;
    foreach (status_seen[k]) status_seen[k] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // size limits and frees on an empty map
    issue(make_cmd(KIND_ALLOC, 0, 0));
    issue(make_cmd(KIND_ALLOC, STORE_BYTES + 1, 0));
    issue(make_cmd(KIND_ALLOC, (1 << SIZE_W) - 1, 0));
    issue(make_cmd(KIND_FREE, 0, 0));
    issue(make_cmd(KIND_FREE, 1, STORE_BYTES - 1));
    issue(make_cmd(KIND_FREE, 2, STORE_BYTES - 1));
    issue(make_cmd(KIND_FREE, STORE_BYTES, STORE_BYTES - 1));
    // small allocations packing the low words
    issue(make_cmd(KIND_ALLOC, 1, 0));
    issue(make_cmd(KIND_ALLOC, UNIT_BYTES, 0));
    issue(make_cmd(KIND_ALLOC, UNIT_BYTES + 1, 0));
    issue(make_cmd(KIND_ALLOC, 31 * UNIT_BYTES, 0));
    issue(make_cmd(KIND_ALLOC, UNIT_BYTES, 0));
    issue(make_cmd(KIND_ALLOC, 27 * UNIT_BYTES, 0));
    // large run from the top, then a whole-store request with no room
    issue(make_cmd(KIND_ALLOC, WORD_W * UNIT_BYTES, 0));
    issue(make_cmd(KIND_ALLOC, STORE_BYTES, 0));
    issue(make_cmd(KIND_FREE, 1, 0));
    issue(make_cmd(KIND_FREE, 1, 0));
    issue(make_cmd(KIND_FREE, UNIT_BYTES, UNIT_BYTES + 77));
    issue(make_cmd(KIND_FREE, WORD_W * UNIT_BYTES, STORE_BYTES - WORD_W * UNIT_BYTES));
    issue(make_cmd(KIND_FREE, 31 * UNIT_BYTES, WORD_W * UNIT_BYTES));
    issue(make_cmd(KIND_FREE, 3 * UNIT_BYTES, 2 * UNIT_BYTES));
    issue(make_cmd(KIND_FREE, 27 * UNIT_BYTES, 5 * UNIT_BYTES));
    // whole store in one block
    issue(make_cmd(KIND_ALLOC, STORE_BYTES, 0));
    issue(make_cmd(KIND_ALLOC, 1, 0));
    issue(make_cmd(KIND_FREE, STORE_BYTES, 0));
    directed_beats = 25;

    track_live = 1'b1;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      gaps_on = !(n >= 300 && n < 450);
      issue(random_cmd());
      random_beats++;
    end
    start <= 1'b0;

    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("%0d command beats (%0d directed, %0d random), peak %0d of %0d units in use",
             directed_beats + random_beats, directed_beats, random_beats,
             peak_units, TOTAL_UNITS);
    $display("results: ok %0d, no free run %0d, bad size %0d, double free %0d, outside %0d",
             status_seen[ST_OK], status_seen[ST_NO_RUN], status_seen[ST_BAD_SIZE],
             status_seen[ST_DOUBLE_FREE], status_seen[ST_OUTSIDE]);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> bitmap_block_allocator.f
hdl/bba_pkg.sv
hdl/bba_ram.sv
hdl/bba_div.sv
hdl/bitmap_block_allocator.sv
hdl/bba_chk.sv
tb/bba_checker.sv
tb/testbench.sv
